FILE: hw/rtl/dfbp_pkg.sv
package dfbp_pkg;

  // default sizes
  localparam int DEF_NODE_COUNT      = 8;
  localparam int DEF_MAX_FRAME_BYTES = 64;
  localparam int DEF_MAX_DELIM_BYTES = 4;

  // field and register widths
  localparam int FRAME_LEN_W = 7;
  localparam int DELIM_LEN_W = 3;
  localparam int DELIM_W     = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int BYTE_W      = 8;

  localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_RESET = 7'd64;

  // the delimiter window holds at most four bytes
  localparam int DELIM_WINDOW_BYTES = DELIM_W / BYTE_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DELIMITER = 2'd2;

  // item actions
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  // result kinds
  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_WR_OPEN,
    S_WR_STORE,
    S_RD_SLOT,
    S_RD_STREAM
  } state_t;

endpackage

FILE: hw/rtl/delimited_frame_buffer_pool_unit.sv
// Frame buffer pool with end-of-frame delimiter detection.
// Items enter on start/action/data_byte, taken at a clock edge with start high
// and busy low. A write item stores one byte in the open frame slot, opening
// one from the free queue (or reusing the oldest completed frame) when needed,
// and gives one acknowledge result. A read item streams the oldest completed
// frame as frame_len results (clamped to 1..MAX_FRAME_BYTES), or one "no
// frame" result if none is waiting. Results appear on kind/accepted/
// frame_byte/last for one cycle each, marked by result_valid; the receiver
// cannot stall them, and last marks the final result of an item.
// Sequencing: a write to an open frame holds busy through S_WR_STORE, a
// write that must open a slot through S_WR_OPEN (the queue memory read) and
// then S_WR_STORE; its result is on the ports in the cycle busy drops. A read
// holds busy through S_RD_SLOT, which reads the completed queue, then through
// S_RD_STREAM, where the frame memory gives one byte per cycle; results trail
// by one register, so the last byte shows in the cycle busy drops. A read
// with no frame waiting keeps busy low and answers next cycle.
// Configuration writes on cfg_write/cfg_index/cfg_data take effect at once.
// Reset (rst, synchronous) empties the completed queue, fills the free queue
// with all slots in order, closes the open frame and restores register
// defaults; no clearing pass is needed, the block is ready right after reset.
module delimited_frame_buffer_pool_unit
  import dfbp_pkg::*;
#(
  parameter int NODE_COUNT      = DEF_NODE_COUNT,
  parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES,
  parameter int MAX_DELIM_BYTES = DEF_MAX_DELIM_BYTES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic                   action,
  input  logic [BYTE_W-1:0]      data_byte,
  input  logic                   cfg_write,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [DELIM_W-1:0]     cfg_data,
  output logic                   result_valid,
  output logic [1:0]             kind,
  output logic                   accepted,
  output logic [BYTE_W-1:0]      frame_byte,
  output logic                   last
);

  localparam int SLOT_W   = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int BYTE_AW  = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;
  localparam int FILL_W   = $clog2(MAX_FRAME_BYTES + 1);
  localparam int CNT_W    = $clog2(NODE_COUNT + 1);
  localparam int STORE_AW = SLOT_W + BYTE_AW;
  localparam int DELIM_LIM = (MAX_DELIM_BYTES < DELIM_WINDOW_BYTES) ?
                             MAX_DELIM_BYTES : DELIM_WINDOW_BYTES;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NODE_COUNT - 1);

  // configuration registers
  logic [FRAME_LEN_W-1:0] frame_len;
  logic [DELIM_LEN_W-1:0] delim_len;
  logic [DELIM_W-1:0]     delimiter;

  // memories
  logic [BYTE_W-1:0] store_mem [2**STORE_AW];
  logic [FILL_W-1:0] fill_mem  [NODE_COUNT];
  logic [SLOT_W-1:0] free_mem  [NODE_COUNT];
  logic [SLOT_W-1:0] done_mem  [NODE_COUNT];
  logic [NODE_COUNT-1:0] free_vld;

  // registered read data
  logic [BYTE_W-1:0] store_rd;
  logic [FILL_W-1:0] fill_rd;
  logic [SLOT_W-1:0] free_rd;
  logic [SLOT_W-1:0] done_rd;

  // queue pointers and counts
  logic [SLOT_W-1:0] free_head, free_tail, done_head, done_tail;
  logic [CNT_W-1:0]  free_count, done_count;

  // open frame and sequencer
  state_t            state, state_next;
  logic              open_valid;
  logic [SLOT_W-1:0] open_slot;
  logic [FILL_W-1:0] open_fill;
  logic [DELIM_W-1:0] recent_bytes;
  logic [BYTE_W-1:0] byte_r;
  logic [SLOT_W-1:0] slot_r;
  logic [FILL_W-1:0] idx;

  // control decisions
  logic              pop_free, pop_done, push_done, push_free;
  logic              emit, emit_acc, emit_last;
  kind_t             emit_kind;
  logic [BYTE_W-1:0] emit_byte;
  logic              store_we, wr_close;

  // effective lengths
  logic [FILL_W-1:0]      flen;
  logic [DELIM_LEN_W-1:0] dlen;
  logic [DELIM_W-1:0]     dmask;
  logic [FILL_W-1:0]      fill_new;
  logic [DELIM_W-1:0]     recent_new;
  logic                   room, delim_hit;
  logic [FILL_W:0]        idx_inc;
  logic [SLOT_W-1:0]      rd_slot;
  logic [STORE_AW-1:0]    store_raddr, store_waddr;

  assign busy = (state != S_IDLE);

  always_comb begin
    if (frame_len == '0) begin
      flen = FILL_W'(1);
    end else if (int'(frame_len) > MAX_FRAME_BYTES) begin
      flen = FILL_W'(MAX_FRAME_BYTES);
    end else begin
      flen = FILL_W'(frame_len);
    end
    dlen = (int'(delim_len) > DELIM_LIM) ? DELIM_LEN_W'(DELIM_LIM) : delim_len;
    for (int b = 0; b < DELIM_WINDOW_BYTES; b++) begin
      dmask[b*BYTE_W +: BYTE_W] = (b < int'(dlen)) ? {BYTE_W{1'b1}} : '0;
    end
  end

  // byte store step of a write
  assign room       = (int'(open_fill) < int'(flen));
  assign fill_new   = open_fill + FILL_W'(1);
  assign recent_new = {recent_bytes[DELIM_W-BYTE_W-1:0], byte_r};
  assign delim_hit  = (dlen != '0) && (int'(fill_new) >= int'(dlen)) &&
                      (((recent_new ^ delimiter) & dmask) == '0);
  assign wr_close   = room ? ((fill_new == flen) || delim_hit) : 1'b1;

  // read addresses: the slot comes straight from the queue in the slot cycle
  assign idx_inc     = {1'b0, idx} + (FILL_W+1)'(1);
  assign rd_slot     = (state == S_RD_SLOT) ? done_rd : slot_r;
  assign store_raddr = (state == S_RD_SLOT) ? {done_rd, BYTE_AW'(0)}
                                            : {slot_r, idx_inc[BYTE_AW-1:0]};
  assign store_waddr = {open_slot, open_fill[BYTE_AW-1:0]};

  // next state and control
  always_comb begin
    state_next = state;
    pop_free   = 1'b0;
    pop_done   = 1'b0;
    push_done  = 1'b0;
    push_free  = 1'b0;
    store_we   = 1'b0;
    emit       = 1'b0;
    emit_kind  = KIND_ACK;
    emit_acc   = 1'b0;
    emit_byte  = '0;
    emit_last  = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (action == ACT_READ) begin
            if (done_count == '0) begin
              emit      = 1'b1;
              emit_kind = KIND_EMPTY;
            end else begin
              state_next = S_RD_SLOT;
            end
          end else if (open_valid) begin
            state_next = S_WR_STORE;
          end else if (free_count != '0 || done_count != '0) begin
            state_next = S_WR_OPEN;
          end else begin
            emit = 1'b1;
          end
        end
      end
      S_WR_OPEN: begin
        pop_free   = (free_count != '0);
        pop_done   = (free_count == '0);
        state_next = S_WR_STORE;
      end
      S_WR_STORE: begin
        store_we   = room;
        push_done  = wr_close;
        emit       = 1'b1;
        emit_acc   = room;
        state_next = S_IDLE;
      end
      S_RD_SLOT: begin
        pop_done   = 1'b1;
        state_next = S_RD_STREAM;
      end
      S_RD_STREAM: begin
        emit      = 1'b1;
        emit_kind = KIND_BYTE;
        emit_byte = (int'(idx) < int'(fill_rd)) ? store_rd : '0;
        emit_last = (int'(idx_inc) == int'(flen));
        if (emit_last) begin
          push_free  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // memories: one read port each, registered, plus one write port
  always_ff @(posedge clk) begin
    store_rd <= store_mem[store_raddr];
    fill_rd  <= fill_mem[rd_slot];
    free_rd  <= free_vld[free_head] ? free_mem[free_head] : free_head;
    done_rd  <= done_mem[done_head];
    if (store_we) begin
      store_mem[store_waddr] <= byte_r;
    end
    if (push_done) begin
      fill_mem[open_slot] <= room ? fill_new : open_fill;
      if (int'(done_count) < NODE_COUNT) begin
        done_mem[done_tail] <= open_slot;
      end
    end
    if (push_free && int'(free_count) < NODE_COUNT) begin
      free_mem[free_tail] <= slot_r;
    end
  end

  // queue pointers, open frame and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      free_head    <= '0;
      free_tail    <= '0;
      free_count   <= CNT_W'(NODE_COUNT);
      free_vld     <= '0;
      done_head    <= '0;
      done_tail    <= '0;
      done_count   <= '0;
      open_valid   <= 1'b0;
      open_slot    <= '0;
      open_fill    <= '0;
      recent_bytes <= '0;
      frame_len    <= FRAME_LEN_RESET;
      delim_len    <= '0;
      delimiter    <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_FRAME_LEN: frame_len <= cfg_data[FRAME_LEN_W-1:0];
          REG_DELIM_LEN: delim_len <= cfg_data[DELIM_LEN_W-1:0];
          REG_DELIMITER: delimiter <= cfg_data;
          default: ;
        endcase
      end
      // opening a slot
      if (pop_free) begin
        free_head  <= (free_head == LAST_SLOT) ? '0 : free_head + SLOT_W'(1);
        free_count <= free_count - CNT_W'(1);
        open_slot  <= free_rd;
      end
      if (pop_done) begin
        done_head  <= (done_head == LAST_SLOT) ? '0 : done_head + SLOT_W'(1);
        done_count <= done_count - CNT_W'(1);
        if (state == S_WR_OPEN) begin
          open_slot <= done_rd;
        end
      end
      if (state == S_WR_OPEN) begin
        open_valid <= 1'b1;
        open_fill  <= '0;
      end
      // storing a byte
      if (store_we) begin
        open_fill    <= fill_new;
        recent_bytes <= recent_new;
      end
      if (push_done) begin
        open_valid <= 1'b0;
        if (int'(done_count) < NODE_COUNT) begin
          done_tail  <= (done_tail == LAST_SLOT) ? '0 : done_tail + SLOT_W'(1);
          done_count <= done_count + CNT_W'(1);
        end
      end
      // returning a slot after its frame was read
      if (push_free && int'(free_count) < NODE_COUNT) begin
        free_vld[free_tail] <= 1'b1;
        free_tail  <= (free_tail == LAST_SLOT) ? '0 : free_tail + SLOT_W'(1);
        free_count <= free_count + CNT_W'(1);
      end
    end
  end

  // item payload and stream position
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      byte_r <= data_byte;
    end
    if (state == S_RD_SLOT) begin
      slot_r <= done_rd;
      idx    <= '0;
    end else if (state == S_RD_STREAM) begin
      idx <= idx_inc[FILL_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    kind       <= emit_kind;
    accepted   <= emit_acc;
    frame_byte <= emit_byte;
    last       <= emit_last;
  end

endmodule

FILE: hw/rtl/dfbp_checker.sv
module dfbp_checker
  import dfbp_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              busy,
  input logic              result_valid,
  input logic [1:0]        kind,
  input logic              accepted,
  input logic [BYTE_W-1:0] frame_byte,
  input logic              last
);

  // acknowledges and empty answers are single results
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && (kind == KIND_ACK || kind == KIND_EMPTY) |-> last)
    else $error("single result item without last");

  // frame bytes never claim a stored write, other kinds carry no byte
  a_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (kind == KIND_BYTE) ? !accepted : (frame_byte == '0))
    else $error("result fields inconsistent with kind");

  // a frame stream has no gaps
  a_stream_gapless: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |=> result_valid && kind == KIND_BYTE)
    else $error("gap inside frame stream");

  // the block stays busy while a frame is still streaming
  a_busy_stream: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |-> busy)
    else $error("frame stream without busy");

endmodule

bind delimited_frame_buffer_pool_unit dfbp_checker u_dfbp_checker (
  .clk          (clk),
  .rst          (rst),
  .busy         (busy),
  .result_valid (result_valid),
  .kind         (kind),
  .accepted     (accepted),
  .frame_byte   (frame_byte),
  .last         (last)
);

FILE: dv/testbench.sv
`timescale 1ns / 100ps

import dfbp_pkg::*;

// one result as it leaves the block
typedef struct {
  kind_t      kind;
  logic       acc;
  logic [7:0] fbyte;
  logic       last;
} pool_result_t;

// frame pool predictor plus the queue of results still to come
class pool_scoreboard;
  logic [7:0]           frame_bytes [DEF_NODE_COUNT][DEF_MAX_FRAME_BYTES];
  int unsigned          fill_count [DEF_NODE_COUNT];
  int unsigned          done_slots [$];
  int unsigned          free_slots [$];
  int unsigned          open_slot;
  bit                   open_valid;
  logic [31:0]          recent;
  logic [FRAME_LEN_W-1:0] frame_len;
  logic [DELIM_LEN_W-1:0] delim_len;
  logic [DELIM_W-1:0]   delimiter;
  pool_result_t         pending_results [$];
  int unsigned          errors;

  function new();
    for (int i = 0; i < DEF_NODE_COUNT; i++) begin
      fill_count[i] = 0;
      free_slots.push_back(i);
    end
    open_slot  = 0;
    open_valid = 1'b0;
    recent     = '0;
    frame_len  = FRAME_LEN_RESET;
    delim_len  = '0;
    delimiter  = '0;
    errors     = 0;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DELIM_W-1:0] val);
    case (idx)
      REG_FRAME_LEN: frame_len = val[FRAME_LEN_W-1:0];
      REG_DELIM_LEN: delim_len = val[DELIM_LEN_W-1:0];
      REG_DELIMITER: delimiter = val;
      default: ;
    endcase
  endfunction

  // frame length as the block applies it
  function int unsigned used_len();
    if (frame_len == 0) return 1;
    if (frame_len > DEF_MAX_FRAME_BYTES) return DEF_MAX_FRAME_BYTES;
    return frame_len;
  endfunction

  // delimiter length clamped to the window
  function int unsigned window_len();
    int unsigned d;
    d = delim_len;
    if (d > DEF_MAX_DELIM_BYTES) d = DEF_MAX_DELIM_BYTES;
    if (d > DELIM_WINDOW_BYTES) d = DELIM_WINDOW_BYTES;
    return d;
  endfunction

  function void add_result(kind_t k, logic acc, logic [7:0] b, logic l);
    pool_result_t r;
    r.kind  = k;
    r.acc   = acc;
    r.fbyte = b;
    r.last  = l;
    pending_results.push_back(r);
  endfunction

  function void predict_write(logic [7:0] b);
    int unsigned flen, d, f;
    bit          close_frame;
    logic        acc;
    logic [31:0] mask;
    flen = used_len();
    d = window_len();
    close_frame = 1'b0;
    acc = 1'b0;
    // open a slot, stealing the oldest completed frame when none is free
    if (!open_valid) begin
      if (free_slots.size() > 0) begin
        open_slot = free_slots.pop_front();
      end else if (done_slots.size() > 0) begin
        open_slot = done_slots.pop_front();
      end else begin
        add_result(KIND_ACK, 1'b0, 8'h00, 1'b1);
        return;
      end
      open_valid = 1'b1;
      fill_count[open_slot] = 0;
    end
    f = fill_count[open_slot];
    if (f < flen) begin
      frame_bytes[open_slot][f] = b;
      f++;
      fill_count[open_slot] = f;
      recent = {recent[23:0], b};
      acc = 1'b1;
      if (f == flen) begin
        close_frame = 1'b1;
      end else if (d != 0 && f >= d) begin
        mask = 32'((64'd1 << (8 * d)) - 64'd1);
        close_frame = ((recent ^ delimiter) & mask) == 32'h0;
      end
    end else begin
      // frame_len lowered under the fill: byte dropped, frame closed
      close_frame = 1'b1;
    end
    if (close_frame) begin
      if (done_slots.size() < DEF_NODE_COUNT) done_slots.push_back(open_slot);
      open_valid = 1'b0;
    end
    add_result(KIND_ACK, acc, 8'h00, 1'b1);
  endfunction

  function void predict_read();
    int unsigned flen, slot;
    logic [7:0]  b;
    flen = used_len();
    if (done_slots.size() == 0) begin
      add_result(KIND_EMPTY, 1'b0, 8'h00, 1'b1);
      return;
    end
    slot = done_slots.pop_front();
    // bytes past the fill read as zero
    for (int unsigned i = 0; i < flen; i++) begin
      b = (i < fill_count[slot]) ? frame_bytes[slot][i] : 8'h00;
      add_result(KIND_BYTE, 1'b0, b, (i + 1 == flen));
    end
    if (free_slots.size() < DEF_NODE_COUNT) free_slots.push_back(slot);
  endfunction

  function void take_item(logic act, logic [7:0] b);
    if (act == ACT_READ) predict_read();
    else predict_write(b);
  endfunction

  function void check_result(logic [1:0] k, logic acc, logic [7:0] b, logic l);
    pool_result_t e;
    if (pending_results.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: unexpected result kind=%0d accepted=%0d byte=%02h last=%0d",
                 $realtime, k, acc, b, l);
      return;
    end
    e = pending_results.pop_front();
    if (k !== e.kind || acc !== e.acc || b !== e.fbyte || l !== e.last) begin
      errors++;
      if (errors <= 10)
        $display("%0t: mismatch exp kind=%0d acc=%0d byte=%02h last=%0d, got %0d %0d %02h %0d",
                 $realtime, e.kind, e.acc, e.fbyte, e.last, k, acc, b, l);
    end
  endfunction
endclass

module testbench;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 action = ACT_WRITE;
  logic [BYTE_W-1:0]    data_byte = '0;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DELIM_W-1:0]   cfg_data = '0;
  logic                 busy;
  logic                 result_valid;
  logic [1:0]           kind;
  logic                 accepted;
  logic [BYTE_W-1:0]    frame_byte;
  logic                 last;

  pool_scoreboard sb;
  int unsigned    stall_cycles = 0;
  int unsigned    idle_pct = 37;

  delimited_frame_buffer_pool_unit dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .data_byte    (data_byte),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .kind         (kind),
    .accepted     (accepted),
    .frame_byte   (frame_byte),
    .last         (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // accepted items feed the predictor, results are checked, stalls are timed
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.take_item(action, data_byte);
      if (result_valid) sb.check_result(kind, accepted, frame_byte, last);
      if ((start && !busy) || result_valid) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // present one item, idling first at the current rate, hold until taken
  task automatic send_item(input logic act, input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    action <= act;
    data_byte <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // drop start and let every expected result arrive
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0 || busy) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DELIM_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic set_config(input logic [FRAME_LEN_W-1:0] flen, input logic [DELIM_LEN_W-1:0] dlen,
                            input logic [DELIM_W-1:0] delim);
    wait_idle();
    write_reg(REG_FRAME_LEN, DELIM_W'(flen));
    write_reg(REG_DELIM_LEN, DELIM_W'(dlen));
    write_reg(REG_DELIMITER, delim);
    write_reg(REG_SPARE, $urandom);
    cfg_write <= 1'b0;
  endtask

  // mostly byte streams with delimiter runs mixed in, some runs cut short
  task automatic run_phase(input int unsigned n_items, input int unsigned read_pct);
    logic [7:0]  burst [$];
    int unsigned d;
    for (int unsigned n = 0; n < n_items; n++) begin
      d = sb.window_len();
      if ($urandom_range(99) < read_pct) begin
        send_item(ACT_READ, 8'($urandom));
      end else begin
        if (burst.size() == 0 && d != 0 && $urandom_range(99) < 20) begin
          for (int k = d - 1; k >= 0; k--) burst.push_back(sb.delimiter[8*k +: 8]);
          if ($urandom_range(99) < 20) void'(burst.pop_back());
        end
        if (burst.size() != 0) send_item(ACT_WRITE, burst.pop_front());
        else send_item(ACT_WRITE, 8'($urandom));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    wait_idle();

    // reset settings: read on empty, partial frame with byte extremes
    send_item(ACT_READ, 8'h00);
    send_item(ACT_WRITE, 8'h00);
    send_item(ACT_WRITE, 8'hFF);
    send_item(ACT_WRITE, 8'hA5);

    // frame_len below the open fill: byte dropped, frame closed
    set_config(7'd2, 3'd0, 32'h0000_0000);
    send_item(ACT_WRITE, 8'h11);
    send_item(ACT_READ, 8'hFF);

    // two-byte delimiter closes a short frame, tail reads as zero
    set_config(7'd4, 3'd2, 32'hFFFF_0D0A);
    send_item(ACT_WRITE, 8'h0D);
    send_item(ACT_WRITE, 8'h0A);
    send_item(ACT_READ, 8'h00);

    // one-byte frames overrun the pool: oldest completed frame is reused
    set_config(7'd1, 3'd7, 32'hFFFF_FFFF);
    for (int i = 0; i < DEF_NODE_COUNT + 1; i++) send_item(ACT_WRITE, 8'($urandom));
    for (int i = 0; i < DEF_NODE_COUNT + 1; i++) send_item(ACT_READ, 8'($urandom));

    // random phases across settings and idling rates
    set_config(7'd0, 3'd0, 32'hFFFF_FFFF);
    run_phase(34, 30);
    set_config(7'd5, 3'd1, 32'h0000_007E);
    run_phase(34, 20);
    idle_pct = 49;
    set_config(7'd127, 3'd4, $urandom);
    run_phase(34, 10);
    set_config(7'd16, 3'd3, $urandom);
    run_phase(34, 20);
    idle_pct = 0;
    set_config(7'd64, 3'd5, $urandom);
    run_phase(34, 10);
    set_config(7'd8, 3'd6, $urandom);
    run_phase(33, 25);

    wait_idle();
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
